>>> rtl/core/bcu_pkg.sv
// ----------------------------------------------------------------------------
// Binomial coefficient unit package
// Widths, microcode encoding and the control program shared by the unit.
// ----------------------------------------------------------------------------
package bcu_pkg;

  localparam int N_WIDTH          = 8;
  localparam int RESULT_WIDTH     = 64;
  localparam int PROD_WIDTH       = N_WIDTH + RESULT_WIDTH;
  localparam int IN_TDATA_WIDTH   = ((2 * N_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_WIDTH  = ((RESULT_WIDTH + 7) / 8) * 8;
  localparam int DIV_CNT_WIDTH    = $clog2(PROD_WIDTH + 1);
  localparam int PC_WIDTH         = 4;

  typedef logic [PC_WIDTH-1:0] pc_t;

  typedef enum logic [3:0] {
    ACT_NOP,
    ACT_LOAD,
    ACT_PREP,
    ACT_MUL,
    ACT_DIV_GO,
    ACT_UPDATE,
    ACT_RES_VALUE,
    ACT_RES_ZERO,
    ACT_RES_SAT
  } act_e;

  typedef enum logic [1:0] {
    WAIT_NONE,
    WAIT_IN,
    WAIT_DIV,
    WAIT_OUT
  } wait_e;

  typedef enum logic [2:0] {
    BR_NEXT,
    BR_JUMP,
    BR_K_GT_N,
    BR_C_GT_K,
    BR_Q_OVF
  } br_e;

  typedef struct packed {
    act_e  act;
    wait_e wait_on;
    br_e   br;
    pc_t   target;
  } uword_t;

  localparam pc_t PC_FETCH   = 4'd0;
  localparam pc_t PC_CHECK   = 4'd1;
  localparam pc_t PC_PREP    = 4'd2;
  localparam pc_t PC_TEST    = 4'd3;
  localparam pc_t PC_MUL     = 4'd4;
  localparam pc_t PC_DIV_GO  = 4'd5;
  localparam pc_t PC_DIV_END = 4'd6;
  localparam pc_t PC_UPDATE  = 4'd7;
  localparam pc_t PC_FINISH  = 4'd8;
  localparam pc_t PC_ZERO    = 4'd9;
  localparam pc_t PC_SAT     = 4'd10;

  function automatic uword_t ucode_rom(pc_t pc);
    uword_t uw;
    case (pc)
      PC_FETCH:   uw = '{ACT_LOAD,      WAIT_IN,   BR_NEXT,   PC_FETCH};
      PC_CHECK:   uw = '{ACT_NOP,       WAIT_NONE, BR_K_GT_N, PC_ZERO};
      PC_PREP:    uw = '{ACT_PREP,      WAIT_NONE, BR_NEXT,   PC_FETCH};
      PC_TEST:    uw = '{ACT_NOP,       WAIT_NONE, BR_C_GT_K, PC_FINISH};
      PC_MUL:     uw = '{ACT_MUL,       WAIT_NONE, BR_NEXT,   PC_FETCH};
      PC_DIV_GO:  uw = '{ACT_DIV_GO,    WAIT_NONE, BR_NEXT,   PC_FETCH};
      PC_DIV_END: uw = '{ACT_NOP,       WAIT_DIV,  BR_Q_OVF,  PC_SAT};
      PC_UPDATE:  uw = '{ACT_UPDATE,    WAIT_NONE, BR_JUMP,   PC_TEST};
      PC_FINISH:  uw = '{ACT_RES_VALUE, WAIT_OUT,  BR_JUMP,   PC_FETCH};
      PC_ZERO:    uw = '{ACT_RES_ZERO,  WAIT_OUT,  BR_JUMP,   PC_FETCH};
      PC_SAT:     uw = '{ACT_RES_SAT,   WAIT_OUT,  BR_JUMP,   PC_FETCH};
      default:    uw = '{ACT_NOP,       WAIT_NONE, BR_JUMP,   PC_FETCH};
    endcase
    return uw;
  endfunction

endpackage

>>> rtl/core/bcu_divider.sv
// ----------------------------------------------------------------------------
// Binomial coefficient unit divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bcu_divider (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [bcu_pkg::PROD_WIDTH-1:0] dividend_i,
  input  logic [bcu_pkg::N_WIDTH-1:0]    divisor_i,
  output logic                           busy_o,
  output logic [bcu_pkg::PROD_WIDTH-1:0] quotient_o
);
  import bcu_pkg::*;

  logic                     busy_q;
  logic [DIV_CNT_WIDTH-1:0] cnt_q;
  logic [N_WIDTH-1:0]       rem_q;
  logic [PROD_WIDTH-1:0]    dq_q;
  logic [N_WIDTH:0]         trial;
  logic [N_WIDTH:0]         diff;
  logic                     fits;
  logic [N_WIDTH-1:0]       rem_d;

  always_comb begin
    trial = {rem_q, dq_q[PROD_WIDTH-1]};
    diff  = trial - {1'b0, divisor_i};
    fits  = (trial >= {1'b0, divisor_i});
    rem_d = fits ? diff[N_WIDTH-1:0] : trial[N_WIDTH-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= DIV_CNT_WIDTH'(PROD_WIDTH);
    end else if (busy_q) begin
      cnt_q <= cnt_q - DIV_CNT_WIDTH'(1);
      if (cnt_q == DIV_CNT_WIDTH'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dq_q  <= dividend_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dq_q  <= {dq_q[PROD_WIDTH-2:0], fits};
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = dq_q;

endmodule

>>> rtl/core/binomial_coefficient_unit.sv
// ----------------------------------------------------------------------------
// Binomial coefficient unit
// Computes C(n,k) with a microcoded multiply and exact-divide loop, saturating
// to all ones with an overflow flag when the value exceeds the result width.
// ----------------------------------------------------------------------------
// The loop runs at most min(k, n-k) times from acceptance to a valid result,
// ending early on overflow and skipped when k exceeds n, which gives zero.
// Each loop step is set by the bit-serial divider plus 5 control steps.
// One item is worked on at a time; the next is accepted the cycle after the
// result register is loaded, even while that result still waits.
// Reset clears the step counter and the result valid flag.
module binomial_coefficient_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // n_value [7:0], k_value [15:8]
  input  logic [bcu_pkg::IN_TDATA_WIDTH-1:0]  s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // coefficient [63:0]
  output logic [bcu_pkg::OUT_TDATA_WIDTH-1:0] m_axis_tdata_o,
  // overflow [0]
  output logic                                m_axis_tuser_o
);
  import bcu_pkg::*;

  pc_t                     pc_q;
  pc_t                     pc_d;
  uword_t                  uw;
  logic                    wait_ok;
  logic                    br_taken;
  logic                    do_act;

  logic [N_WIDTH-1:0]      n_q;
  logic [N_WIDTH-1:0]      k_q;
  logic [N_WIDTH-1:0]      c_q;
  logic [N_WIDTH-1:0]      falling_q;
  logic [N_WIDTH-1:0]      n_minus_k;
  logic [RESULT_WIDTH-1:0] value_q;
  logic [PROD_WIDTH-1:0]   prod_q;

  logic                    div_start;
  logic                    div_busy;
  logic [PROD_WIDTH-1:0]   quot;
  logic                    q_ovf;

  logic                    out_valid_q;
  logic [RESULT_WIDTH-1:0] out_coef_q;
  logic                    out_ovf_q;
  logic                    out_write;

  assign uw        = ucode_rom(pc_q);
  assign n_minus_k = n_q - k_q;
  assign q_ovf     = |quot[PROD_WIDTH-1:RESULT_WIDTH];

  always_comb begin
    case (uw.wait_on)
      WAIT_NONE: wait_ok = 1'b1;
      WAIT_IN:   wait_ok = s_axis_tvalid_i;
      WAIT_DIV:  wait_ok = !div_busy;
      WAIT_OUT:  wait_ok = !out_valid_q || m_axis_tready_i;
      default:   wait_ok = 1'b1;
    endcase
    case (uw.br)
      BR_NEXT:   br_taken = 1'b0;
      BR_JUMP:   br_taken = 1'b1;
      BR_K_GT_N: br_taken = (k_q > n_q);
      BR_C_GT_K: br_taken = (c_q > k_q);
      BR_Q_OVF:  br_taken = q_ovf;
      default:   br_taken = 1'b0;
    endcase
    do_act = wait_ok;
    if (!wait_ok) begin
      pc_d = pc_q;
    end else if (br_taken) begin
      pc_d = uw.target;
    end else begin
      pc_d = pc_q + pc_t'(1);
    end
  end

  assign div_start = do_act && (uw.act == ACT_DIV_GO);
  assign out_write = do_act && ((uw.act == ACT_RES_VALUE) || (uw.act == ACT_RES_ZERO) ||
                                (uw.act == ACT_RES_SAT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= PC_FETCH;
      out_valid_q <= 1'b0;
    end else begin
      pc_q <= pc_d;
      if (out_write) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_act) begin
      case (uw.act)
        ACT_LOAD: begin
          n_q <= s_axis_tdata_i[N_WIDTH-1:0];
          k_q <= s_axis_tdata_i[2*N_WIDTH-1:N_WIDTH];
        end
        ACT_PREP: begin
          if (k_q > n_minus_k) begin
            k_q <= n_minus_k;
          end
          value_q   <= RESULT_WIDTH'(1);
          c_q       <= N_WIDTH'(1);
          falling_q <= n_q;
        end
        ACT_MUL: begin
          prod_q <= {{N_WIDTH{1'b0}}, value_q} * {{RESULT_WIDTH{1'b0}}, falling_q};
        end
        ACT_UPDATE: begin
          value_q   <= quot[RESULT_WIDTH-1:0];
          falling_q <= falling_q - N_WIDTH'(1);
          c_q       <= c_q + N_WIDTH'(1);
        end
        ACT_RES_VALUE: begin
          out_coef_q <= value_q;
          out_ovf_q  <= 1'b0;
        end
        ACT_RES_ZERO: begin
          out_coef_q <= '0;
          out_ovf_q  <= 1'b0;
        end
        ACT_RES_SAT: begin
          out_coef_q <= '1;
          out_ovf_q  <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  bcu_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (c_q),
    .busy_o     (div_busy),
    .quotient_o (quot)
  );

  assign s_axis_tready_o = (uw.wait_on == WAIT_IN);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_TDATA_WIDTH'(out_coef_q);
  assign m_axis_tuser_o  = out_ovf_q;

endmodule

>>> rtl/core/bcu_assert.sv
// ----------------------------------------------------------------------------
// Binomial coefficient unit port checks
// Checks on the ports of the unit over time, bound to the top level.
// ----------------------------------------------------------------------------
module bcu_assert (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                s_axis_tvalid_i,
  input logic                                s_axis_tready_o,
  input logic                                m_axis_tvalid_o,
  input logic                                m_axis_tready_i,
  input logic [bcu_pkg::OUT_TDATA_WIDTH-1:0] m_axis_tdata_o,
  input logic                                m_axis_tuser_o
);

  // Only one item is in work at a time.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken while an item is in work");

  // A saturated result is all ones.
  a_sat_ones: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> (m_axis_tdata_o == '1))
    else $error("overflow result is not saturated");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

  // A fresh result frees the input side at once.
  a_rose_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> s_axis_tready_o)
    else $error("input not ready after result");

endmodule

bind binomial_coefficient_unit bcu_assert u_bcu_assert (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

>>> test/tb.sv
// ----------------------------------------------------------------------------
// Binomial coefficient unit testbench
// Streams (n, k) items into the unit and checks each coefficient and overflow
// flag against typed table values or a wide-arithmetic model of the multiply
// and exact-divide loop. A directed table covers the edge cases, then random
// items follow under three idle patterns on the input and output sides.
// ----------------------------------------------------------------------------
module tb;

  import bcu_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int NUM_DIRECTED = 25;
  localparam int NUM_RANDOM   = 75;
  localparam int DRAIN_CYCLES = 100;
  localparam int MAX_REPORTS  = 10;
  localparam logic [PROD_WIDTH-1:0] MAX_COEF = {RESULT_WIDTH{1'b1}};
  localparam logic [RESULT_WIDTH-1:0] ALL_ONES = {RESULT_WIDTH{1'b1}};

  typedef struct packed {
    logic [RESULT_WIDTH-1:0] coef;
    logic                    ovf;
  } coef_result_t;

  typedef struct packed {
    logic [N_WIDTH-1:0]      n;
    logic [N_WIDTH-1:0]      k;
    bit                      typed;
    logic [RESULT_WIDTH-1:0] coef;
    logic                    ovf;
  } coef_vector_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [IN_TDATA_WIDTH-1:0]  s_tdata = '0;
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [OUT_TDATA_WIDTH-1:0] m_tdata;
  logic                       m_tuser;

  coef_result_t pending_coefs[$];
  int           mismatch_count = 0;
  int           send_idle_pct = 31;
  int           recv_idle_pct = 53;

  coef_vector_t directed_rows [0:NUM_DIRECTED-1] = '{
    '{8'd0,   8'd0,   1'b1, 64'd1,     1'b0},
    '{8'd255, 8'd255, 1'b1, 64'd1,     1'b0},
    '{8'd0,   8'd255, 1'b1, 64'd0,     1'b0},
    '{8'd254, 8'd255, 1'b1, 64'd0,     1'b0},
    '{8'd255, 8'd0,   1'b1, 64'd1,     1'b0},
    '{8'd255, 8'd1,   1'b1, 64'd255,   1'b0},
    '{8'd255, 8'd254, 1'b1, 64'd255,   1'b0},
    '{8'd255, 8'd2,   1'b1, 64'd32385, 1'b0},
    '{8'd1,   8'd1,   1'b1, 64'd1,     1'b0},
    '{8'd1,   8'd0,   1'b1, 64'd1,     1'b0},
    '{8'd2,   8'd1,   1'b1, 64'd2,     1'b0},
    '{8'd10,  8'd5,   1'b1, 64'd252,   1'b0},
    '{8'd255, 8'd128, 1'b1, ALL_ONES,  1'b1},
    '{8'd255, 8'd127, 1'b1, ALL_ONES,  1'b1},
    '{8'd170, 8'd255, 1'b1, 64'd0,     1'b0},
    '{8'd85,  8'd170, 1'b1, 64'd0,     1'b0},
    '{8'd67,  8'd33,  1'b0, 64'd0,     1'b0},
    '{8'd67,  8'd34,  1'b0, 64'd0,     1'b0},
    '{8'd68,  8'd34,  1'b0, 64'd0,     1'b0},
    '{8'd66,  8'd33,  1'b0, 64'd0,     1'b0},
    '{8'd64,  8'd32,  1'b0, 64'd0,     1'b0},
    '{8'd100, 8'd10,  1'b0, 64'd0,     1'b0},
    '{8'd170, 8'd85,  1'b0, 64'd0,     1'b0},
    '{8'd200, 8'd7,   1'b0, 64'd0,     1'b0},
    '{8'd128, 8'd64,  1'b0, 64'd0,     1'b0}
  };

  binomial_coefficient_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  function automatic coef_result_t binomial_of(logic [N_WIDTH-1:0] n,
                                               logic [N_WIDTH-1:0] k);
    logic [PROD_WIDTH-1:0] running;
    logic [PROD_WIDTH-1:0] quotient;
    logic [N_WIDTH-1:0]    steps;
    coef_result_t          res;
    int                    c;
    res.coef = '0;
    res.ovf  = 1'b0;
    if (k > n) begin
      return res;
    end
    steps   = (k > n - k) ? n - k : k;
    running = 1;
    for (c = 1; c <= steps; c++) begin
      quotient = running * (PROD_WIDTH'(n) - PROD_WIDTH'(c) + 1) / PROD_WIDTH'(c);
      if (quotient > MAX_COEF) begin
        res.coef = ALL_ONES;
        res.ovf  = 1'b1;
        return res;
      end
      running = quotient;
    end
    res.coef = running[RESULT_WIDTH-1:0];
    return res;
  endfunction

  task automatic send_pair(input logic [N_WIDTH-1:0] n, input logic [N_WIDTH-1:0] k,
                           input bit typed, input coef_result_t typed_res);
    @(negedge clk_i);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {k, n};
    do @(posedge clk_i); while (!s_tready);
    pending_coefs.push_back(typed ? typed_res : binomial_of(n, k));
  endtask

  task automatic send_random_pairs(input int count);
    logic [N_WIDTH-1:0] n;
    logic [N_WIDTH-1:0] k;
    int                 sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      n   = $urandom_range(1) ? N_WIDTH'($urandom_range(67)) : N_WIDTH'($urandom_range(255));
      if (sel < 15) begin
        k = N_WIDTH'($urandom_range(255));
      end else if (sel < 30) begin
        k = (n >> 1) + N_WIDTH'($urandom_range(1));
      end else begin
        k = N_WIDTH'($urandom_range(n));
      end
      send_pair(n, k, 1'b0, '0);
    end
  endtask

  task automatic wait_all_results();
    while (pending_coefs.size() != 0) @(posedge clk_i);
  endtask

  always @(negedge clk_i) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    coef_result_t want;
    if (m_tvalid && m_tready) begin
      if (pending_coefs.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("unexpected item: coefficient %0d overflow %0b", m_tdata, m_tuser);
        end
      end else begin
        want = pending_coefs.pop_front();
        if (m_tdata !== want.coef || m_tuser !== want.ovf) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("mismatch: coefficient exp %0d got %0d, overflow exp %0b got %0b",
                     want.coef, m_tdata, want.ovf, m_tuser);
          end
        end
      end
    end
  end

  initial begin
    #(2 * HALF_PERIOD * 4000000);
    $display("status: fail");
    $finish;
  end

  initial begin
    coef_result_t typed_res;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      typed_res.coef = directed_rows[i].coef;
      typed_res.ovf  = directed_rows[i].ovf;
      send_pair(directed_rows[i].n, directed_rows[i].k, directed_rows[i].typed, typed_res);
    end
    send_random_pairs(NUM_RANDOM / 3);

    @(negedge clk_i);
    s_tvalid <= 1'b0;
    wait_all_results();
    send_idle_pct = 53;
    recv_idle_pct = 31;
    send_random_pairs(NUM_RANDOM / 3);

    @(negedge clk_i);
    s_tvalid <= 1'b0;
    wait_all_results();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random_pairs(NUM_RANDOM - 2 * (NUM_RANDOM / 3));

    @(negedge clk_i);
    s_tvalid <= 1'b0;
    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && pending_coefs.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
